[sv/ieval_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ieval_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 128;
  localparam int unsigned VALUE_WIDTH_DEF = 16;
  localparam int unsigned RESULT_WIDTH    = 16;
  localparam int unsigned CHAR_WIDTH      = 8;

  localparam logic [CHAR_WIDTH-1:0] CHAR_HASH  = 8'h23;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LPAR  = 8'h28;
  localparam logic [CHAR_WIDTH-1:0] CHAR_RPAR  = 8'h29;
  localparam logic [CHAR_WIDTH-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'd48;

  typedef enum logic [2:0] {
    OP_END  = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_LPAR = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_PAREN = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CH_NUM,
    CH_END,
    CH_LPAR,
    CH_RPAR,
    CH_ADD,
    CH_SUB,
    CH_MUL,
    CH_DIV
  } chr_cls_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RED_CHECK,
    S_RED_A,
    S_RED_WAIT,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic    load_char;
    logic    push_num;
    logic    push_op;
    op_e     push_code;
    logic    pop_op;
    logic    latch_err;
    status_e err_code;
    logic    red_arith;
    logic    alu_start;
    logic    red_alu;
    logic    emit;
  } ieval_cmd_t;

  typedef struct packed {
    chr_cls_e cls;
    op_e      op_top;
    op_e      red_op;
    logic     opnd_lt2;
    logic     err_set;
    logic     b_zero;
    logic     alu_done;
    logic     out_free;
  } ieval_stat_t;

  function automatic chr_cls_e classify(input logic [CHAR_WIDTH-1:0] c);
    chr_cls_e r;
    case (c)
      CHAR_HASH:  r = CH_END;
      CHAR_LPAR:  r = CH_LPAR;
      CHAR_RPAR:  r = CH_RPAR;
      CHAR_PLUS:  r = CH_ADD;
      CHAR_MINUS: r = CH_SUB;
      CHAR_STAR:  r = CH_MUL;
      CHAR_SLASH: r = CH_DIV;
      default:    r = CH_NUM;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/ieval_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ieval_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[sv/ieval_alu.sv]
`timescale 1ns / 1ps
`default_nettype none

module ieval_alu #(
  parameter int unsigned WIDTH = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             is_div_i,
  input  wire logic [WIDTH-1:0] a_i,
  input  wire logic [WIDTH-1:0] b_i,
  output      logic [WIDTH-1:0] res_o,
  output      logic             done_o
);

  localparam int unsigned SW = $clog2(WIDTH + 1);
  localparam logic [SW-1:0] STEPS = SW'(WIDTH);
  localparam logic [SW-1:0] LAST  = SW'(1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [SW-1:0]    cnt_q, cnt_d;
  logic             is_div_q, is_div_d;
  logic             neg_q, neg_d;
  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;
  logic [WIDTH-1:0] r_q, r_d;

  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   diff;
  logic             ge;
  logic [WIDTH-1:0] mag_a;
  logic [WIDTH-1:0] mag_b;

  assign mag_a  = a_i[WIDTH-1] ? ('0 - a_i) : a_i;
  assign mag_b  = b_i[WIDTH-1] ? ('0 - b_i) : b_i;
  assign rem_sh = {r_q, x_q[WIDTH-1]};
  assign diff   = rem_sh - {1'b0, y_q};
  assign ge     = ~diff[WIDTH];

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    is_div_d = is_div_q;
    neg_d    = neg_q;
    x_d      = x_q;
    y_d      = y_q;
    r_d      = r_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = STEPS;
      is_div_d = is_div_i;
      neg_d    = a_i[WIDTH-1] ^ b_i[WIDTH-1];
      r_d      = '0;
      if (is_div_i) begin
        x_d = mag_a;
        y_d = mag_b;
      end else begin
        x_d = a_i;
        y_d = b_i;
      end
    end else if (busy_q) begin
      cnt_d = cnt_q - LAST;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      if (is_div_q) begin
        r_d = ge ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        x_d = {x_q[WIDTH-2:0], ge};
      end else begin
        r_d = y_q[0] ? (r_q + x_q) : r_q;
        x_d = {x_q[WIDTH-2:0], 1'b0};
        y_d = {1'b0, y_q[WIDTH-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_div_q <= is_div_d;
    neg_q    <= neg_d;
    x_q      <= x_d;
    y_q      <= y_d;
    r_q      <= r_d;
  end

  assign res_o  = is_div_q ? (neg_q ? ('0 - x_q) : x_q) : r_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

[sv/ieval_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module ieval_datapath import ieval_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [CHAR_WIDTH-1:0]   char_in_i,
  input  wire ieval_cmd_t              cmd_i,
  output      ieval_stat_t             stat_o,
  input  wire logic                    out_ready_i,
  output      logic                    out_valid_o,
  output      logic [RESULT_WIDTH-1:0] result_value_o,
  output      logic [2:0]              status_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned RW = RESULT_WIDTH;
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  logic [CHAR_WIDTH-1:0] char_q;
  logic [CW-1:0]         op_cnt_q, op_cnt_d;
  op_e                   op_top_q, op_top_d;
  logic                  op_load_q;
  op_e                   red_op_q;
  logic [CW-1:0]         opnd_cnt_q, opnd_cnt_d;
  logic [VW-1:0]         top_val_q, top_val_d;
  status_e               err_q, err_d;
  logic                  out_valid_q, out_valid_d;
  logic [RW-1:0]         out_val_q;
  status_e               out_st_q;

  op_e           op_top;
  logic [2:0]    op_rdata;
  logic          op_full;
  logic          op_push_ok;
  logic [CW-1:0] op_rd_idx;
  logic [VW-1:0] opnd_rdata;
  logic          opnd_full;
  logic          num_push_ok;
  logic          red_wr;
  logic [CW-1:0] opnd_rd_idx;
  logic [AW-1:0] opnd_waddr;
  logic [VW-1:0] opnd_wdata;
  logic [VW-1:0] num_val;
  logic [VW-1:0] arith_res;
  logic [VW-1:0] alu_res;
  logic          alu_done;
  logic [VW-1:0] red_val;
  logic          set_en;
  status_e       set_code;
  status_e       fin_st;
  logic [VW-1:0] fin_val;
  logic [VW+RW-1:0] fin_ext;

  assign op_full     = op_cnt_q >= DEPTH_C;
  assign opnd_full   = opnd_cnt_q >= DEPTH_C;
  assign op_push_ok  = cmd_i.push_op && !op_full;
  assign num_push_ok = cmd_i.push_num && !opnd_full;
  assign red_wr      = cmd_i.red_arith || cmd_i.red_alu;
  assign op_rd_idx   = op_cnt_q - TWO_C;
  assign opnd_rd_idx = opnd_cnt_q - TWO_C;

  assign op_top = op_load_q ? ((op_cnt_q == ONE_C) ? OP_END : op_e'(op_rdata)) : op_top_q;

  ieval_ram #(
    .WIDTH(3),
    .DEPTH(STACK_DEPTH)
  ) u_op_ram (
    .clk_i  (clk_i),
    .we_i   (op_push_ok),
    .waddr_i(op_cnt_q[AW-1:0]),
    .wdata_i(cmd_i.push_code),
    .raddr_i(op_rd_idx[AW-1:0]),
    .rdata_o(op_rdata)
  );

  assign num_val    = VW'(char_q) - VW'(CHAR_ZERO);
  assign opnd_waddr = cmd_i.push_num ? opnd_cnt_q[AW-1:0] : opnd_rd_idx[AW-1:0];
  assign opnd_wdata = cmd_i.push_num ? num_val : red_val;

  ieval_ram #(
    .WIDTH(VW),
    .DEPTH(STACK_DEPTH)
  ) u_opnd_ram (
    .clk_i  (clk_i),
    .we_i   (num_push_ok || red_wr),
    .waddr_i(opnd_waddr),
    .wdata_i(opnd_wdata),
    .raddr_i(opnd_rd_idx[AW-1:0]),
    .rdata_o(opnd_rdata)
  );

  ieval_alu #(
    .WIDTH(VW)
  ) u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.alu_start),
    .is_div_i(red_op_q == OP_DIV),
    .a_i     (opnd_rdata),
    .b_i     (top_val_q),
    .res_o   (alu_res),
    .done_o  (alu_done)
  );

  always_comb begin
    case (red_op_q)
      OP_ADD:  arith_res = opnd_rdata + top_val_q;
      OP_SUB:  arith_res = opnd_rdata - top_val_q;
      default: arith_res = '0;
    endcase
  end

  assign red_val = cmd_i.red_alu ? alu_res : arith_res;

  always_comb begin
    if (err_q != ST_OK) begin
      fin_st = err_q;
    end else if (op_top == OP_LPAR) begin
      fin_st = ST_PAREN;
    end else if (opnd_cnt_q == '0) begin
      fin_st = ST_UNDER;
    end else begin
      fin_st = ST_OK;
    end
  end

  assign fin_val = (fin_st == ST_OK) ? top_val_q : '0;
  assign fin_ext = {{RW{1'b0}}, fin_val};

  always_comb begin
    set_en   = 1'b0;
    set_code = ST_OK;
    if (cmd_i.latch_err) begin
      set_en   = 1'b1;
      set_code = cmd_i.err_code;
    end else if ((cmd_i.push_op && op_full) || (cmd_i.push_num && opnd_full)) begin
      set_en   = 1'b1;
      set_code = ST_OVER;
    end
  end

  always_comb begin
    op_cnt_d    = op_cnt_q;
    op_top_d    = op_load_q ? op_top : op_top_q;
    opnd_cnt_d  = opnd_cnt_q;
    top_val_d   = top_val_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.emit) begin
      op_cnt_d    = ONE_C;
      op_top_d    = OP_END;
      opnd_cnt_d  = '0;
      err_d       = ST_OK;
      out_valid_d = 1'b1;
    end else begin
      if (op_push_ok) begin
        op_cnt_d = op_cnt_q + ONE_C;
        op_top_d = cmd_i.push_code;
      end else if (cmd_i.pop_op) begin
        op_cnt_d = op_cnt_q - ONE_C;
      end
      if (num_push_ok) begin
        opnd_cnt_d = opnd_cnt_q + ONE_C;
        top_val_d  = num_val;
      end else if (red_wr) begin
        opnd_cnt_d = opnd_cnt_q - ONE_C;
        top_val_d  = red_val;
      end
      if (set_en && err_q == ST_OK) begin
        err_d = set_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_cnt_q    <= ONE_C;
      op_top_q    <= OP_END;
      op_load_q   <= 1'b0;
      opnd_cnt_q  <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      op_cnt_q    <= op_cnt_d;
      op_top_q    <= op_top_d;
      op_load_q   <= cmd_i.pop_op && !cmd_i.emit;
      opnd_cnt_q  <= opnd_cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_val_q <= top_val_d;
    if (cmd_i.load_char) begin
      char_q <= char_in_i;
    end
    if (cmd_i.pop_op) begin
      red_op_q <= op_top;
    end
    if (cmd_i.emit) begin
      out_val_q <= fin_ext[RW-1:0];
      out_st_q  <= fin_st;
    end
  end

  assign stat_o.cls      = classify(char_q);
  assign stat_o.op_top   = op_top;
  assign stat_o.red_op   = red_op_q;
  assign stat_o.opnd_lt2 = opnd_cnt_q < TWO_C;
  assign stat_o.err_set  = err_q != ST_OK;
  assign stat_o.b_zero   = top_val_q == '0;
  assign stat_o.alu_done = alu_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_val_q;
  assign status_o       = out_st_q;

  a_op_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_cnt_q != '0)
    else $error("Operator stack lost its end marker.");

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_cnt_q <= DEPTH_C) && (opnd_cnt_q <= DEPTH_C))
    else $error("Stack count exceeds the stack depth.");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_OK && !cmd_i.emit) |=> (err_q == $past(err_q)))
    else $error("A latched error changed before the expression ended.");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (opnd_cnt_q == '0 && op_cnt_q == ONE_C && err_q == ST_OK && out_valid_q))
    else $error("Finishing an expression did not restore the empty state.");

endmodule

`default_nettype wire

[sv/ieval_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ieval_ctrl import ieval_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire ieval_stat_t stat_i,
  output      ieval_cmd_t  cmd_o
);

  state_e state_q, state_d;

  logic top_arith;
  logic top_muldiv;
  logic cls_muldiv;
  logic red_go;

  assign top_muldiv = (stat_i.op_top == OP_MUL) || (stat_i.op_top == OP_DIV);
  assign top_arith  = top_muldiv || (stat_i.op_top == OP_ADD) || (stat_i.op_top == OP_SUB);
  assign cls_muldiv = (stat_i.cls == CH_MUL) || (stat_i.cls == CH_DIV);
  assign red_go     = !stat_i.err_set && (cls_muldiv ? top_muldiv : top_arith);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.push_code = OP_END;
    cmd_o.err_code  = ST_OK;
    in_ready_o      = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_char = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.cls == CH_END) begin
          state_d = S_RED_CHECK;
        end else if (stat_i.err_set) begin
          state_d = S_IDLE;
        end else begin
          case (stat_i.cls)
            CH_LPAR: begin
              cmd_o.push_op   = 1'b1;
              cmd_o.push_code = OP_LPAR;
              state_d         = S_IDLE;
            end
            CH_NUM: begin
              cmd_o.push_num = 1'b1;
              state_d        = S_IDLE;
            end
            default: begin
              state_d = S_RED_CHECK;
            end
          endcase
        end
      end
      S_RED_CHECK: begin
        if (red_go) begin
          cmd_o.pop_op = 1'b1;
          if (stat_i.opnd_lt2) begin
            cmd_o.latch_err = 1'b1;
            cmd_o.err_code  = ST_UNDER;
          end else begin
            state_d = S_RED_A;
          end
        end else begin
          state_d = S_IDLE;
          case (stat_i.cls)
            CH_END: begin
              state_d = S_EMIT;
            end
            CH_RPAR: begin
              if (!stat_i.err_set) begin
                if (stat_i.op_top == OP_LPAR) begin
                  cmd_o.pop_op = 1'b1;
                end else begin
                  cmd_o.latch_err = 1'b1;
                  cmd_o.err_code  = ST_PAREN;
                end
              end
            end
            CH_ADD: begin
              cmd_o.push_op   = !stat_i.err_set;
              cmd_o.push_code = OP_ADD;
            end
            CH_SUB: begin
              cmd_o.push_op   = !stat_i.err_set;
              cmd_o.push_code = OP_SUB;
            end
            CH_MUL: begin
              cmd_o.push_op   = !stat_i.err_set;
              cmd_o.push_code = OP_MUL;
            end
            CH_DIV: begin
              cmd_o.push_op   = !stat_i.err_set;
              cmd_o.push_code = OP_DIV;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RED_A: begin
        if (stat_i.red_op == OP_MUL ||
            (stat_i.red_op == OP_DIV && !stat_i.b_zero)) begin
          cmd_o.alu_start = 1'b1;
          state_d         = S_RED_WAIT;
        end else begin
          cmd_o.red_arith = 1'b1;
          if (stat_i.red_op == OP_DIV) begin
            cmd_o.latch_err = 1'b1;
            cmd_o.err_code  = ST_DIVZ;
          end
          state_d = S_RED_CHECK;
        end
      end
      S_RED_WAIT: begin
        if (stat_i.alu_done) begin
          cmd_o.red_alu = 1'b1;
          state_d       = S_RED_CHECK;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/infix_expression_evaluator.sv]
// An operand byte or '(' is pushed directly; an operator byte or ')' first runs its reductions.
// A reduction by + or -, or by / with a zero divisor, is done directly; an underflow latches an error;
// any other by * or / goes through the shared bit-serial multiply and divide unit.
// With an error latched, any byte but '#' is dropped. A '#' runs any reductions and then emits the result.
// A result is valid the cycle after it is emitted and waits in its own register; the next '#' waits for it.
// Reset is asynchronous and active low; it empties both stacks and clears any latched error.
`timescale 1ns / 1ps
`default_nettype none

module infix_expression_evaluator import ieval_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic [CHAR_WIDTH-1:0]          char_in_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output      logic signed [RESULT_WIDTH-1:0] result_value_o,
  output      logic [2:0]                     status_o
);

  ieval_cmd_t  cmd;
  ieval_stat_t stat;

  ieval_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ieval_datapath #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_in_i     (char_in_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .result_value_o(result_value_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire
